// ===== hdl/imuca_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helper functions for the attitude estimator
package imuca_pkg;

  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 16;

  // angle accumulator fraction bits inside the cordic
  localparam int ZFRAC = 24;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 26;
  localparam int GAIN_W      = 17;
  localparam int OFFSET_W    = 26;

  localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'd65536;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd64225;

  localparam logic [CFG_INDEX_W-1:0] REG_BLEND_GAIN   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PITCH_OFFSET = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROLL_OFFSET  = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_YAW_OFFSET   = 8'd3;

  localparam logic signed [47:0] SAT_MAX = 48'sd2147483647;
  localparam logic signed [47:0] SAT_MIN = -48'sd2147483648;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] pitch_out;
    logic signed [31:0] roll_out;
    logic signed [31:0] yaw_out;
  } attitude_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // atan(2^-i) in degrees with ZFRAC fraction bits
  function automatic logic signed [33:0] atan_deg(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:  r = 34'sd754974720;
      5'd1:  r = 34'sd445687602;
      5'd2:  r = 34'sd235489088;
      5'd3:  r = 34'sd119537938;
      5'd4:  r = 34'sd60000934;
      5'd5:  r = 34'sd30029717;
      5'd6:  r = 34'sd15018523;
      5'd7:  r = 34'sd7509720;
      5'd8:  r = 34'sd3754917;
      5'd9:  r = 34'sd1877466;
      5'd10: r = 34'sd938734;
      5'd11: r = 34'sd469367;
      5'd12: r = 34'sd234684;
      5'd13: r = 34'sd117342;
      5'd14: r = 34'sd58671;
      5'd15: r = 34'sd29335;
      5'd16: r = 34'sd14668;
      5'd17: r = 34'sd7334;
      5'd18: r = 34'sd3667;
      5'd19: r = 34'sd1833;
      5'd20: r = 34'sd917;
      5'd21: r = 34'sd458;
      5'd22: r = 34'sd229;
      5'd23: r = 34'sd115;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/imuca_cordic.sv =====
`timescale 1ns / 1ps
// iterative vectoring cordic, atan2(y, x) in degrees, one micro-rotation per cycle
module imuca_cordic #(
  parameter int CORDIC_STEPS    = imuca_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = imuca_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] y_in,
  input  logic signed [15:0] x_in,
  output logic               done,
  output logic signed [31:0] angle
);
  import imuca_pkg::*;

  localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [CW-1:0] LAST = CW'(CORDIC_STEPS - 1);
  localparam int ZSHIFT = ZFRAC - ANGLE_FRAC_BITS;
  localparam logic signed [33:0] ZHALF = 34'sd1 <<< (ZSHIFT - 1);
  localparam logic signed [33:0] Z90 = 34'sd1509949440;

  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic [CW-1:0]      cnt;
  logic               active;
  logic               zero_vec;

  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [33:0] zr;

  assign xs = 34'(x_in) <<< 14;
  assign ys = 34'(y_in) <<< 14;
  assign dx = y >>> cnt;
  assign dy = x >>> cnt;
  assign zr = (z + ZHALF) >>> ZSHIFT;
  assign angle = zero_vec ? 32'sd0 : 32'(zr);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      zero_vec <= (x_in == 16'sd0) && (y_in == 16'sd0);
      // left half plane: pre-rotate by a quarter turn
      if (xs < 0) begin
        if (ys >= 0) begin
          x <= ys;
          y <= -xs;
          z <= Z90;
        end else begin
          x <= -ys;
          y <= xs;
          z <= -Z90;
        end
      end else begin
        x <= xs;
        y <= ys;
        z <= '0;
      end
    end else if (active) begin
      if (y > 0) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + atan_deg(5'(cnt));
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - atan_deg(5'(cnt));
      end
    end
  end

endmodule

// ===== hdl/imu_complementary_attitude.sv =====
`timescale 1ns / 1ps
// complementary-filter attitude estimator: gyro integration blended with accel angles
// a taken sample passes S_START_P, S_WAIT_P, S_START_R, S_WAIT_R, S_MUL_P, S_ADD_P,
// S_MUL_R, S_ADD_R and S_DONE; one sample at a time, paced by the shared cordic unit
// that runs the pitch and roll atan2 one after the other; sample_stall is high meanwhile
// a finished result waits in the output register while the next sample is taken
// reset (rst, synchronous): estimates cleared, gain 64225, offsets zero, no result pending
module imu_complementary_attitude #(
  parameter int CORDIC_STEPS    = imuca_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = imuca_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  imuca_pkg::sample_t                    sample,
  output logic                                  attitude_valid,
  input  logic                                  attitude_stall,
  output imuca_pkg::attitude_t                  attitude,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [imuca_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [imuca_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import imuca_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_START_P = 10'b00_0000_0010,
    S_WAIT_P  = 10'b00_0000_0100,
    S_START_R = 10'b00_0000_1000,
    S_WAIT_R  = 10'b00_0001_0000,
    S_MUL_P   = 10'b00_0010_0000,
    S_ADD_P   = 10'b00_0100_0000,
    S_MUL_R   = 10'b00_1000_0000,
    S_ADD_R   = 10'b01_0000_0000,
    S_DONE    = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  logic [GAIN_W-1:0]          blend_gain;
  logic signed [OFFSET_W-1:0] pitch_offset;
  logic signed [OFFSET_W-1:0] roll_offset;
  logic signed [OFFSET_W-1:0] yaw_offset;

  logic signed [31:0] pitch_est;
  logic signed [31:0] roll_est;
  logic signed [31:0] yaw_est;

  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [31:0] gyro_pitch;
  logic signed [31:0] gyro_roll;
  logic signed [31:0] gyro_yaw;
  logic signed [31:0] acc_pitch;
  logic signed [31:0] acc_roll;
  logic signed [50:0] prod;

  logic               take;
  logic               out_load;
  logic               cordic_start;
  logic               cordic_done;
  logic signed [15:0] cordic_y;
  logic signed [31:0] cordic_angle;

  logic signed [47:0] inc_x;
  logic signed [47:0] inc_y;
  logic signed [47:0] inc_z;
  logic [GAIN_W-1:0]  gain_eff;
  logic signed [31:0] sel_gyro;
  logic signed [31:0] sel_acc;
  logic signed [32:0] diff;
  logic signed [51:0] bsum;
  logic signed [31:0] blended;

  // floor(rate * 10 * 2^frac / 2^15)
  function automatic logic signed [47:0] rate_inc(input logic signed [15:0] r);
    logic signed [47:0] w;
    w = (48'(r) * 48'sd10) <<< ANGLE_FRAC_BITS;
    return w >>> 15;
  endfunction

  assign inc_x = rate_inc(sample.rate_x);
  assign inc_y = rate_inc(sample.rate_y);
  assign inc_z = rate_inc(sample.rate_z);

  assign take         = sample_valid && !sample_stall;
  assign sample_stall = (state != S_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_load     = (state == S_DONE) && (!attitude_valid || !attitude_stall);

  // pitch uses atan2(ay, az), roll uses atan2(ax, az)
  assign cordic_start = (state == S_START_P) || (state == S_START_R);
  assign cordic_y     = (state == S_START_P) ? accel_y : accel_x;

  imuca_cordic #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .y_in  (cordic_y),
    .x_in  (accel_z),
    .done  (cordic_done),
    .angle (cordic_angle)
  );

  // g*gyro + (1-g)*acc rewritten as acc + g*(gyro - acc), one shared multiplier
  assign gain_eff = (blend_gain > GAIN_ONE) ? GAIN_ONE : blend_gain;
  assign sel_gyro = ((state == S_MUL_P) || (state == S_ADD_P)) ? gyro_pitch : gyro_roll;
  assign sel_acc  = ((state == S_MUL_P) || (state == S_ADD_P)) ? acc_pitch : acc_roll;
  assign diff     = 33'(sel_gyro) - 33'(sel_acc);
  assign bsum     = (52'(sel_acc) <<< 16) + 52'(prod) + 52'sd32768;
  assign blended  = sat32(48'(bsum >>> 16));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (take) state_next = S_START_P;
      S_START_P: state_next = S_WAIT_P;
      S_WAIT_P:  if (cordic_done) state_next = S_START_R;
      S_START_R: state_next = S_WAIT_R;
      S_WAIT_R:  if (cordic_done) state_next = S_MUL_P;
      S_MUL_P:   state_next = S_ADD_P;
      S_ADD_P:   state_next = S_MUL_R;
      S_MUL_R:   state_next = S_ADD_R;
      S_ADD_R:   state_next = S_DONE;
      S_DONE:    if (out_load) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      attitude_valid <= 1'b0;
      blend_gain     <= GAIN_RESET;
      pitch_offset   <= '0;
      roll_offset    <= '0;
      yaw_offset     <= '0;
      pitch_est      <= '0;
      roll_est       <= '0;
      yaw_est        <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        attitude_valid <= 1'b1;
      end else if (!attitude_stall) begin
        attitude_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_BLEND_GAIN:   blend_gain   <= cfg_data[GAIN_W-1:0];
          REG_PITCH_OFFSET: pitch_offset <= cfg_data;
          REG_ROLL_OFFSET:  roll_offset  <= cfg_data;
          REG_YAW_OFFSET:   yaw_offset   <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_ADD_P) pitch_est <= blended;
      if (state == S_ADD_R) roll_est <= blended;
      if (out_load) yaw_est <= gyro_yaw;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      accel_x    <= sample.accel_x;
      accel_y    <= sample.accel_y;
      accel_z    <= sample.accel_z;
      gyro_pitch <= sat32(48'(pitch_est) + inc_x);
      gyro_roll  <= sat32(48'(roll_est) + inc_y);
      gyro_yaw   <= sat32(48'(yaw_est) + inc_z);
    end
    if ((state == S_WAIT_P) && cordic_done) acc_pitch <= cordic_angle;
    if ((state == S_WAIT_R) && cordic_done) acc_roll <= cordic_angle;
    if ((state == S_MUL_P) || (state == S_MUL_R)) begin
      prod <= $signed({1'b0, gain_eff}) * diff;
    end
    if (out_load) begin
      attitude.pitch_out <= sat32(48'(pitch_est) - 48'(pitch_offset));
      attitude.roll_out  <= sat32(48'(roll_est) - 48'(roll_offset));
      attitude.yaw_out   <= sat32(48'(gyro_yaw) - 48'(yaw_offset));
    end
  end

endmodule

// ===== hdl/imuca_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the attitude estimator, bound to the top level
module imuca_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 sample_valid,
  input logic                 sample_stall,
  input logic                 attitude_valid,
  input logic                 attitude_stall,
  input imuca_pkg::attitude_t attitude,
  input logic                 cfg_ready
);
  import imuca_pkg::*;

  // a held result beat keeps its value
  assert property (@(posedge clk) disable iff (rst)
    attitude_valid && attitude_stall |=> attitude_valid && $stable(attitude))
    else $error("held attitude beat changed");

  // once a sample is taken the block is checked busy through S_START_P and on entering S_WAIT_P
  assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall ##1 sample_stall)
    else $error("sample taken while previous one in work");

  // no result can appear right after a sample beat
  assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> !$rose(attitude_valid))
    else $error("result appeared too early");

  // reset leaves no result pending
  assert property (@(posedge clk) rst |=> !attitude_valid)
    else $error("result pending after reset");

  assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");

endmodule

bind imu_complementary_attitude imuca_checker u_imuca_checker (
  .clk            (clk),
  .rst            (rst),
  .sample_valid   (sample_valid),
  .sample_stall   (sample_stall),
  .attitude_valid (attitude_valid),
  .attitude_stall (attitude_stall),
  .attitude       (attitude),
  .cfg_ready      (cfg_ready)
);
